### rtl/tts_pkg.sv
// Package for the timer tick task scheduler.
// Holds item kind codes and the stream payload layout; no dependencies.
`default_nettype none

package tts_pkg;

  localparam int KIND_W  = 1;
  localparam int INDEX_W = 3;
  localparam int PRIO_W  = 8;
  localparam int TIME_W  = 16;

  localparam logic [KIND_W-1:0] KIND_TICK  = 1'b0;
  localparam logic [KIND_W-1:0] KIND_WRITE = 1'b1;

  // Slave-side tdata layout.
  localparam int IN_INDEX_LSB = 0;
  localparam int IN_PRIO_LSB  = IN_INDEX_LSB + INDEX_W;
  localparam int IN_TIME_LSB  = IN_PRIO_LSB + PRIO_W;
  localparam int IN_DATA_W    = 32;

  // Master-side tdata layout.
  localparam int OUT_TASK_LSB     = 0;
  localparam int OUT_SWITCHED_BIT = OUT_TASK_LSB + INDEX_W;
  localparam int OUT_REFILLED_BIT = OUT_SWITCHED_BIT + 1;
  localparam int OUT_NEEDED_BIT   = OUT_REFILLED_BIT + 1;
  localparam int OUT_NOREADY_BIT  = OUT_NEEDED_BIT + 1;
  localparam int OUT_TIME_LSB     = OUT_NOREADY_BIT + 1;
  localparam int OUT_DATA_W       = 24;

endpackage

`default_nettype wire

### rtl/timer_tick_task_scheduler.sv
// Timer tick task scheduler: a task table memory with one shared compare unit.
// Uses tts_pkg for kind codes and payload layout.
// A tick decrements the running task's time; when it runs out, or from idle, it scans the table,
// and an aging refill pass may scan it once more. A write item stores the slot and reports the
// running task's time. One item is in flight at a time and a stalled result holds the block;
// the table scan reads one slot per cycle through the single memory read port. Reset idles the
// running slot, sets shortest-first mode and clears the per-slot valid bits at once; there is
// no clearing pass.
`default_nettype none

module timer_tick_task_scheduler #(
  parameter int NUM_TASKS  = 8,
  parameter int TIME_WIDTH = 16,
  parameter int PRIO_WIDTH = 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic                           cfg_wdata,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // tdata: task_index, priority_value, time_value (from bit 0 up).
  input  wire logic [tts_pkg::IN_DATA_W-1:0]  s_tdata,
  // tuser: kind.
  input  wire logic [tts_pkg::KIND_W-1:0]     s_tuser,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // tdata: running_task, switched, refilled, refill_needed, no_ready, running_time.
  output logic [tts_pkg::OUT_DATA_W-1:0]      m_tdata
);
  import tts_pkg::*;

  localparam int SLOT_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int WORD_W = PRIO_WIDTH + TIME_WIDTH;
  localparam int SUM_W  = ((TIME_WIDTH > PRIO_WIDTH) ? TIME_WIDTH : PRIO_WIDTH) + 1;
  localparam logic [SLOT_W-1:0]     SLOT_ONE  = SLOT_W'(1);
  localparam logic [SLOT_W-1:0]     SLOT_LAST = SLOT_W'(NUM_TASKS - 1);
  localparam logic [TIME_WIDTH-1:0] TIME_MAX  = {TIME_WIDTH{1'b1}};

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_DEC    = 9'b000000010,
    S_SCAN0  = 9'b000000100,
    S_SCAN   = 9'b000001000,
    S_REFILL = 9'b000010000,
    S_WRITE  = 9'b000100000,
    S_RUNRD  = 9'b001000000,
    S_RUNDAT = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_t;

  state_t state;

  logic [WORD_W-1:0]     mem [NUM_TASKS];
  logic [NUM_TASKS-1:0]  valid;
  logic [WORD_W-1:0]     rd_q;
  logic                  rd_ok;

  logic                  mode;
  logic [SLOT_W-1:0]     running;
  logic [SLOT_W-1:0]     cnt;
  logic [SLOT_W-1:0]     best;
  logic [TIME_WIDTH-1:0] best_time;
  logic [PRIO_WIDTH-1:0] best_prio;
  logic [SLOT_W-1:0]     lat_slot;
  logic                  lat_ok;
  logic [PRIO_WIDTH-1:0] lat_prio;
  logic [TIME_WIDTH-1:0] lat_time;
  logic [TIME_WIDTH-1:0] res_time;
  logic                  res_switched;
  logic                  res_refilled;
  logic                  res_needed;
  logic                  res_no_ready;

  logic [INDEX_W-1:0]    in_index;
  logic [SLOT_W-1:0]     rd_addr;
  logic                  wr_en;
  logic [SLOT_W-1:0]     wr_addr;
  logic [WORD_W-1:0]     wr_data;
  logic [TIME_WIDTH-1:0] eff_time;
  logic [PRIO_WIDTH-1:0] eff_prio;
  logic [TIME_WIDTH-1:0] dec_time;
  logic [SUM_W-1:0]      aged_sum;
  logic [TIME_WIDTH-1:0] aged_time;
  logic [TIME_WIDTH-1:0] cand_time;
  logic                  take;
  logic [SLOT_W-1:0]     best_next;
  logic [TIME_WIDTH-1:0] best_time_next;
  logic [PRIO_WIDTH-1:0] best_prio_next;
  logic                  last;

  assign s_tready = (state == S_IDLE);
  assign in_index = s_tdata[IN_INDEX_LSB +: INDEX_W];

  assign eff_time  = rd_ok ? rd_q[TIME_WIDTH-1:0] : '0;
  assign eff_prio  = rd_ok ? rd_q[TIME_WIDTH +: PRIO_WIDTH] : '0;
  assign dec_time  = (eff_time != '0) ? eff_time - TIME_WIDTH'(1) : '0;
  assign aged_sum  = SUM_W'(eff_time >> 1) + SUM_W'(eff_prio);
  assign aged_time = (aged_sum > SUM_W'(TIME_MAX)) ? TIME_MAX : TIME_WIDTH'(aged_sum);
  assign cand_time = (state == S_REFILL) ? aged_time : eff_time;
  assign last      = (cnt == SLOT_LAST);

  always_comb begin
    if (mode) begin
      take = (cand_time != '0) && (eff_prio != '0) && (eff_prio >= best_prio);
    end else begin
      take = (cand_time != '0) && ((best_time == '0) || (cand_time < best_time));
    end
    best_next      = take ? cnt : best;
    best_time_next = take ? cand_time : best_time;
    best_prio_next = take ? eff_prio : best_prio;
  end

  always_comb begin
    rd_addr = running;
    wr_en   = 1'b0;
    wr_addr = running;
    wr_data = {eff_prio, dec_time};
    case (state)
      S_IDLE: begin
        rd_addr = (running != '0) ? running : SLOT_ONE;
      end
      S_DEC: begin
        wr_en = 1'b1;
      end
      S_SCAN0: begin
        rd_addr = SLOT_ONE;
      end
      S_SCAN: begin
        rd_addr = last ? SLOT_ONE : cnt + SLOT_ONE;
      end
      S_REFILL: begin
        rd_addr = last ? SLOT_ONE : cnt + SLOT_ONE;
        wr_en   = 1'b1;
        wr_addr = cnt;
        wr_data = {eff_prio, aged_time};
      end
      S_WRITE: begin
        wr_en   = lat_ok;
        wr_addr = lat_slot;
        wr_data = {lat_prio, lat_time};
      end
      default: begin
        rd_addr = running;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q  <= mem[rd_addr];
    rd_ok <= valid[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
    end else if (cfg_we) begin
      mode <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      running <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            lat_slot     <= SLOT_W'(in_index);
            lat_ok       <= (in_index != '0) && (int'(in_index) < NUM_TASKS);
            lat_prio     <= PRIO_WIDTH'(s_tdata[IN_PRIO_LSB +: PRIO_W]);
            lat_time     <= TIME_WIDTH'(s_tdata[IN_TIME_LSB +: TIME_W]);
            res_switched <= 1'b0;
            res_refilled <= 1'b0;
            res_needed   <= 1'b0;
            res_no_ready <= 1'b0;
            cnt          <= SLOT_ONE;
            best         <= '0;
            best_time    <= '0;
            best_prio    <= '0;
            if (s_tuser == KIND_WRITE) begin
              state <= S_WRITE;
            end else if (running != '0) begin
              state <= S_DEC;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_DEC: begin
          if (dec_time != '0) begin
            res_time <= dec_time;
            state    <= S_OUT;
          end else begin
            state <= S_SCAN0;
          end
        end
        S_SCAN0: begin
          state <= S_SCAN;
        end
        S_SCAN, S_REFILL: begin
          if (!last) begin
            cnt       <= cnt + SLOT_ONE;
            best      <= best_next;
            best_time <= best_time_next;
            best_prio <= best_prio_next;
          end else if (best_next != '0) begin
            running      <= best_next;
            res_switched <= (best_next != running);
            res_time     <= best_time_next;
            state        <= S_OUT;
          end else if (!mode) begin
            res_needed <= 1'b1;
            res_time   <= '0;
            state      <= S_OUT;
          end else if (state == S_SCAN) begin
            res_refilled <= 1'b1;
            cnt          <= SLOT_ONE;
            best         <= '0;
            best_time    <= '0;
            best_prio    <= '0;
            state        <= S_REFILL;
          end else begin
            res_no_ready <= 1'b1;
            res_time     <= '0;
            state        <= S_OUT;
          end
        end
        S_WRITE: begin
          state <= S_RUNRD;
        end
        S_RUNRD: begin
          state <= S_RUNDAT;
        end
        S_RUNDAT: begin
          res_time <= eff_time;
          state    <= S_OUT;
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_OUT && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!m_tvalid || m_tready)) begin
      m_tdata <= OUT_DATA_W'({TIME_W'(res_time), res_no_ready, res_needed, res_refilled,
                              res_switched, INDEX_W'(running)});
    end
  end

endmodule

`default_nettype wire

### rtl/tts_checker.sv
// Port-level checks for the timer tick task scheduler, bound to the top level.
// Uses tts_pkg for the payload layout.
`default_nettype none

module tts_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           s_tvalid,
  input wire logic                           s_tready,
  input wire logic                           m_tvalid,
  input wire logic                           m_tready,
  input wire logic [tts_pkg::OUT_DATA_W-1:0] m_tdata
);
  import tts_pkg::*;

  // After reset the block is ready for a transfer and holds no result.
  assert property (@(posedge clk) rst |=> (s_tready && !m_tvalid))
    else $error("not idle after reset");

  // One item at a time: a transfer in closes the input side.
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input ready right after a transfer");

  // A stalled result holds.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  // Shortest-mode and priority-mode flags never appear together, and an empty
  // choice never reports a switch.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[OUT_NEEDED_BIT] || m_tdata[OUT_NOREADY_BIT])) |->
      (!m_tdata[OUT_SWITCHED_BIT] &&
       !(m_tdata[OUT_NEEDED_BIT] && m_tdata[OUT_REFILLED_BIT])))
    else $error("inconsistent result flags");

endmodule

bind timer_tick_task_scheduler tts_checker u_tts_checker (.*);

`default_nettype wire
